/* sv/dns_response_a_record_extractor_macros.svh */
// ----------------------------------------------------------------------------
// dns response a-record extractor assertion macros
// shared concurrent check forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef DNS_RESPONSE_A_RECORD_EXTRACTOR_MACROS_SVH
`define DNS_RESPONSE_A_RECORD_EXTRACTOR_MACROS_SVH

// property that holds at every edge outside reset
`define DRE_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define DRE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dre_pkg.sv */
// ----------------------------------------------------------------------------
// dre_pkg
// types, codes and constants shared by the a-record extractor modules
// ----------------------------------------------------------------------------
package dre_pkg;

  localparam int OUT_DEPTH_DEFAULT = 4;

  localparam logic [7:0]  NAME_MARK_MASK  = 8'hc0;
  localparam logic [7:0]  RCODE_MASK      = 8'h0f;
  localparam logic [3:0]  HEADER_LAST     = 4'd11;
  localparam logic [3:0]  RCODE_INDEX     = 4'd3;
  localparam logic [3:0]  QDCOUNT_HI      = 4'd4;
  localparam logic [3:0]  QDCOUNT_LO      = 4'd5;
  localparam logic [3:0]  ANCOUNT_HI      = 4'd6;
  localparam logic [3:0]  ANCOUNT_LO      = 4'd7;
  localparam logic [3:0]  QUESTION_LAST   = 4'd3;
  localparam logic [3:0]  TYPE_BYTES      = 4'd2;
  localparam logic [3:0]  RDLEN_FIRST     = 4'd8;
  localparam logic [3:0]  ANSWER_LAST     = 4'd9;
  localparam logic [3:0]  ADDR_BYTES      = 4'd4;
  localparam logic [15:0] RECORD_TYPE_A   = 16'd1;
  localparam logic [15:0] COUNT_MAX       = 16'hffff;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME_LEN,
    PH_NAME_LABEL,
    PH_NAME_PTR,
    PH_FIXED,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_RESOLVED,
    ST_SERVER_ERROR,
    ST_NO_ADDRESS,
    ST_TRUNCATED
  } status_t;

  typedef struct packed {
    logic        end_of_packet;
    logic [31:0] ipv4_address;
    logic        address_short;
    status_t     status;
    logic [15:0] address_count;
  } result_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } push_t;

endpackage

/* sv/dre_parser.sv */
// ----------------------------------------------------------------------------
// dre_parser
// per-byte parser state and the results that one registered byte produces
// ----------------------------------------------------------------------------
`include "dns_response_a_record_extractor_macros.svh"

module dre_parser
  import dre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] packet_byte,
  input  logic       last_byte,
  output push_t      push,
  output result_t    res_a,
  output result_t    res_b
);

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  header_index, header_index_next;
  logic        server_error, server_error_next;
  logic [15:0] questions_left, questions_left_next;
  logic [15:0] answers_left, answers_left_next;
  logic [15:0] skip_left, skip_left_next;
  logic [3:0]  field_index, field_index_next;
  logic [15:0] field_accumulator, field_accumulator_next;
  logic [15:0] record_type, record_type_next;
  logic [31:0] address_accumulator, address_accumulator_next;
  logic [15:0] found_count, found_count_next;

  logic    fin;
  logic    addr_short;
  result_t addr_res;
  result_t stat_res;
  status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PH_HEADER;
      header_index        <= '0;
      server_error        <= 1'b0;
      questions_left      <= '0;
      answers_left        <= '0;
      skip_left           <= '0;
      field_index         <= '0;
      field_accumulator   <= '0;
      record_type         <= '0;
      address_accumulator <= '0;
      found_count         <= '0;
    end else if (step) begin
      parse_phase         <= parse_phase_next;
      header_index        <= header_index_next;
      server_error        <= server_error_next;
      questions_left      <= questions_left_next;
      answers_left        <= answers_left_next;
      skip_left           <= skip_left_next;
      field_index         <= field_index_next;
      field_accumulator   <= field_accumulator_next;
      record_type         <= record_type_next;
      address_accumulator <= address_accumulator_next;
      found_count         <= found_count_next;
    end
  end

  always_comb begin
    parse_phase_next         = parse_phase;
    header_index_next        = header_index;
    server_error_next        = server_error;
    questions_left_next      = questions_left;
    answers_left_next        = answers_left;
    skip_left_next           = skip_left;
    field_index_next         = field_index;
    field_accumulator_next   = field_accumulator;
    record_type_next         = record_type;
    address_accumulator_next = address_accumulator;
    found_count_next         = found_count;
    fin                      = 1'b0;
    addr_short               = 1'b0;
    addr_res                 = '0;
    stat_res                 = '0;
    st                       = ST_RESOLVED;
    push                     = '0;
    res_a                    = '0;
    res_b                    = '0;

    unique case (parse_phase)
      PH_HEADER: begin
        if (header_index == RCODE_INDEX && (packet_byte & RCODE_MASK) != 8'd0) begin
          server_error_next = 1'b1;
        end else if (header_index == QDCOUNT_HI || header_index == QDCOUNT_LO) begin
          questions_left_next = {questions_left[7:0], packet_byte};
        end else if (header_index == ANCOUNT_HI || header_index == ANCOUNT_LO) begin
          answers_left_next = {answers_left[7:0], packet_byte};
        end
        if (header_index >= HEADER_LAST) begin
          header_index_next = '0;
          if (server_error_next) begin
            parse_phase_next = PH_DONE;
          end else if (questions_left_next != 16'd0 || answers_left_next != 16'd0) begin
            parse_phase_next = PH_NAME_LEN;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end else begin
          header_index_next = header_index + 4'd1;
        end
      end
      PH_NAME_LEN: begin
        if (packet_byte == 8'd0) begin
          parse_phase_next = PH_FIXED;
          field_index_next = '0;
        end else if ((packet_byte & NAME_MARK_MASK) != 8'd0) begin
          parse_phase_next = PH_NAME_PTR;
        end else begin
          skip_left_next   = {8'd0, packet_byte};
          parse_phase_next = PH_NAME_LABEL;
        end
      end
      PH_NAME_LABEL: begin
        skip_left_next = skip_left - 16'd1;
        if (skip_left_next == 16'd0) begin
          parse_phase_next = PH_NAME_LEN;
        end
      end
      PH_NAME_PTR: begin
        parse_phase_next = PH_FIXED;
        field_index_next = '0;
      end
      PH_FIXED: begin
        if (questions_left != 16'd0) begin
          if (field_index >= QUESTION_LAST) begin
            questions_left_next = questions_left - 16'd1;
            if (questions_left_next != 16'd0 || answers_left != 16'd0) begin
              parse_phase_next = PH_NAME_LEN;
            end else begin
              parse_phase_next = PH_DONE;
            end
          end else begin
            field_index_next = field_index + 4'd1;
          end
        end else begin
          if (field_index < TYPE_BYTES) begin
            record_type_next = {record_type[7:0], packet_byte};
          end else if (field_index >= RDLEN_FIRST) begin
            field_accumulator_next = {field_accumulator[7:0], packet_byte};
          end
          if (field_index >= ANSWER_LAST) begin
            skip_left_next           = field_accumulator_next;
            field_index_next         = '0;
            address_accumulator_next = '0;
            if (field_accumulator_next == 16'd0) begin
              fin = 1'b1;
            end else begin
              parse_phase_next = PH_DATA;
            end
          end else begin
            field_index_next = field_index + 4'd1;
          end
        end
      end
      PH_DATA: begin
        if (field_index < ADDR_BYTES) begin
          address_accumulator_next = {address_accumulator[23:0], packet_byte};
          field_index_next         = field_index + 4'd1;
        end
        skip_left_next = skip_left - 16'd1;
        if (skip_left_next == 16'd0) begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // end of an answer record
    if (fin) begin
      if (record_type_next == RECORD_TYPE_A) begin
        addr_short = field_accumulator_next < 16'd4;
        if (found_count_next != COUNT_MAX) begin
          found_count_next = found_count_next + 16'd1;
        end
        addr_res.end_of_packet = 1'b0;
        addr_res.ipv4_address  = addr_short ? 32'd0 : address_accumulator_next;
        addr_res.address_short = addr_short;
        addr_res.status        = ST_RESOLVED;
        addr_res.address_count = found_count_next;
        push.a_valid           = step;
      end
      answers_left_next = answers_left_next - 16'd1;
      if (questions_left_next != 16'd0 || answers_left_next != 16'd0) begin
        parse_phase_next = PH_NAME_LEN;
      end else begin
        parse_phase_next = PH_DONE;
      end
    end

    // start of an answer's fixed fields
    if (parse_phase_next == PH_FIXED && field_index_next == 4'd0 &&
        questions_left_next == 16'd0) begin
      record_type_next       = '0;
      field_accumulator_next = '0;
    end

    if (server_error_next) begin
      st = ST_SERVER_ERROR;
    end else if (parse_phase_next != PH_DONE) begin
      st = ST_TRUNCATED;
    end else if (found_count_next == 16'd0) begin
      st = ST_NO_ADDRESS;
    end else begin
      st = ST_RESOLVED;
    end
    stat_res.end_of_packet = 1'b1;
    stat_res.ipv4_address  = '0;
    stat_res.address_short = 1'b0;
    stat_res.status        = st;
    stat_res.address_count = found_count_next;

    res_a = addr_res;
    if (last_byte && step) begin
      if (push.a_valid) begin
        res_b        = stat_res;
        push.b_valid = 1'b1;
      end else begin
        res_a        = stat_res;
        push.a_valid = 1'b1;
      end
    end

    // datagram closed: back to reset values
    if (last_byte) begin
      parse_phase_next         = PH_HEADER;
      header_index_next        = '0;
      server_error_next        = 1'b0;
      questions_left_next      = '0;
      answers_left_next        = '0;
      skip_left_next           = '0;
      field_index_next         = '0;
      field_accumulator_next   = '0;
      record_type_next         = '0;
      address_accumulator_next = '0;
      found_count_next         = '0;
    end
  end

  `DRE_CHECK(a_idle_no_push, !step |-> !push.a_valid && !push.b_valid, "push without a byte")
  `DRE_CHECK(a_last_status, step && last_byte |-> push.a_valid && (res_a.end_of_packet || (push.b_valid && res_b.end_of_packet)), "last byte gave no status")
  `DRE_CHECK_NEXT(a_last_clears, step && last_byte, parse_phase == PH_HEADER && found_count == 16'd0, "state not cleared after datagram")

endmodule

/* sv/dre_result_queue.sv */
// ----------------------------------------------------------------------------
// dre_result_queue
// small result queue taking up to two results a cycle, one out per cycle unless result_stall
// ----------------------------------------------------------------------------
`include "dns_response_a_record_extractor_macros.svh"

module dre_result_queue
  import dre_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH_DEFAULT
)
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  result_t res_a,
  input  result_t res_b,
  output logic    room,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t res_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   wr_ptr_b;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    pop          = result_valid && !result_stall;
    wr_ptr_b     = ptr_inc(wr_ptr);
    wr_ptr_next  = wr_ptr;
    if (push.a_valid && push.b_valid) begin
      wr_ptr_next = ptr_inc(wr_ptr_b);
    end else if (push.a_valid) begin
      wr_ptr_next = wr_ptr_b;
    end
    rd_ptr_next  = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next   = count + CNT_W'(push.a_valid) + CNT_W'(push.b_valid) - CNT_W'(pop);
    room         = count <= CNT_W'(DEPTH - 2);
    result_valid = count != '0;
    res_out      = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      entries[wr_ptr] <= res_a;
    end
    if (push.b_valid) begin
      entries[wr_ptr_b] <= res_b;
    end
  end

  `DRE_CHECK(a_count_bound, count <= CNT_W'(DEPTH), "queue overfilled")
  `DRE_CHECK(a_push_order, push.b_valid |-> push.a_valid, "second slot pushed alone")

endmodule

/* sv/dns_response_a_record_extractor.sv */
// ----------------------------------------------------------------------------
// dns_response_a_record_extractor
// pulls type-1 answer addresses and a closing status out of a dns response
// ----------------------------------------------------------------------------
// usage:
//   input channel: packet_byte and last_byte under item_valid / item_stall,
//   one datagram byte per item, last_byte high on the final byte.
//   output channel: result fields under result_valid / result_stall. each
//   type-1 answer gives one address item (end_of_packet 0); the final byte
//   gives one status item (end_of_packet 1) after any address it closes.
//   results: a byte is held in the input register, parsed when the queue
//   has room, and its results are written into the result queue.
//   throughput: one byte per cycle while item_stall is low; the parser state
//   updates once per byte in a single registered pass, and a result queue of
//   OUT_DEPTH entries absorbs the two items a last byte may produce.
//   stall: item_stall rises when a byte waits in the input register and the
//   queue has fewer than two free entries; no item is dropped.
//   reset: rst (synchronous) empties the queue and returns the parser to the
//   start of a datagram header.
// ----------------------------------------------------------------------------
module dns_response_a_record_extractor
  import dre_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  packet_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        end_of_packet,
  output logic [31:0] ipv4_address,
  output logic        address_short,
  output logic [1:0]  status,
  output logic [15:0] address_count
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       room;
  logic       step;
  push_t      push;
  result_t    res_a;
  result_t    res_b;
  result_t    res_out;

  assign step       = s1_valid && room;
  assign item_stall = s1_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_byte <= packet_byte;
      s1_last <= last_byte;
    end
  end

  dre_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .packet_byte (s1_byte),
    .last_byte   (s1_last),
    .push        (push),
    .res_a       (res_a),
    .res_b       (res_b)
  );

  dre_result_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .res_a        (res_a),
    .res_b        (res_b),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_out      (res_out)
  );

  assign end_of_packet = res_out.end_of_packet;
  assign ipv4_address  = res_out.ipv4_address;
  assign address_short = res_out.address_short;
  assign status        = res_out.status;
  assign address_count = res_out.address_count;

endmodule
